[hdl/wheel_odometry_integrator_assert.svh]
// Assertion macros used by the checker of the odometry integrator.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef WHEEL_ODOMETRY_INTEGRATOR_ASSERT_SVH
`define WHEEL_ODOMETRY_INTEGRATOR_ASSERT_SVH

// Same-cycle implication.
`define WODO_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WODO_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/wodo_pkg.sv]
package wodo_pkg;

  localparam int CNT_W   = 32;
  localparam int ANG_W   = 32;
  localparam int POS_W   = 48;
  localparam int XW      = 58;  // CORDIC vector, Q.24 with gain headroom
  localparam int ZW      = 34;  // CORDIC residual angle
  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [31:0] MPT_RESET = 32'd7906077;
  localparam logic [31:0] APM_RESET = 32'd683565276;
  localparam logic [31:0] INV_GAIN  = 32'h9B74EDA8;

  localparam int ATAN_DEPTH = 32;
  localparam int ATAN_IDX_W = 5;

  typedef enum logic {
    CFG_MPT = 1'b0,
    CFG_APM = 1'b1
  } cfg_index_t;

  localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic                 start;
    logic signed [XW-1:0] x;
    logic signed [ZW-1:0] z;
  } rot_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
  } rot_rsp_t;

endpackage

[hdl/wodo_mul.sv]
// Shared 64x32 unsigned multiplier built from one 32x32 multiplier used twice.
// The result is registered through the ph1 and ph2 phases, flagged by a one-cycle done.
module wodo_mul (
  input  logic               clk,
  input  logic               rst,
  input  wodo_pkg::mul_req_t req,
  output wodo_pkg::mul_rsp_t rsp
);

  logic        ph1;
  logic        ph2;
  logic        done;
  logic [31:0] a_hi;
  logic [31:0] b_r;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] p;
  logic [63:0] p_lo;
  logic [wodo_pkg::PROD_W-1:0] prod;

  assign op_a = req.start ? req.a[31:0] : a_hi;
  assign op_b = req.start ? req.b : b_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph1  <= 1'b0;
      ph2  <= 1'b0;
      done <= 1'b0;
    end else begin
      ph1  <= req.start;
      ph2  <= ph1;
      done <= ph2;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_hi <= req.a[63:32];
      b_r  <= req.b;
    end
    p <= op_a * op_b;
    if (ph1) begin
      p_lo <= p;
    end
    // combine high and low partial products
    if (ph2) begin
      prod <= {p + {32'd0, p_lo[63:32]}, p_lo[31:0]};
    end
  end

  assign rsp.done = done;
  assign rsp.prod = prod;

endmodule

[hdl/wodo_cordic.sv]
// Iterative CORDIC rotator, one micro-rotation per cycle.
module wodo_cordic #(
  parameter int STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  wodo_pkg::rot_req_t req,
  output wodo_pkg::rot_rsp_t rsp
);

  localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic                           busy;
  logic                           done;
  logic [CW-1:0]                  step;
  logic signed [wodo_pkg::XW-1:0] x;
  logic signed [wodo_pkg::XW-1:0] y;
  logic signed [wodo_pkg::ZW-1:0] z;
  logic signed [wodo_pkg::XW-1:0] xs;
  logic signed [wodo_pkg::XW-1:0] ys;
  logic signed [wodo_pkg::ZW-1:0] at;

  assign xs = x >>> step;
  assign ys = y >>> step;
  assign at = $signed({2'b00,
                       wodo_pkg::ATAN_TAB[wodo_pkg::ATAN_IDX_W'(step)]});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x <= req.x;
      y <= '0;
      z <= req.z;
    end else if (busy) begin
      // rotate toward zero residual angle
      if (!z[wodo_pkg::ZW-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.x    = x;
  assign rsp.y    = y;

endmodule

[hdl/wheel_odometry_integrator.sv]
// Differential drive odometry: each input transaction is one telemetry sample
// (timestamp plus four wrapping encoder counts). The first sample after reset
// only primes the stored counts and yields no output transaction; each later
// sample yields one output with the timestamp, the updated x/y position
// (signed Q32.16 metres, saturating at the 48-bit limits) and the heading held
// before this step (binary angle, a full turn is 2^32, wrapping). Write
// metres_per_tick (index 0) and angle_per_metre (index 1) only while idle.
// One sample is processed at a time: in_ready stays low from acceptance until
// the result is loaded into the output register, so a new sample is taken
// only after the last one is through. Processing runs through the setup
// states S_SUM, S_ADD and S_ABS, four passes through the shared 64x32
// multiplier, the rotator (one CORDIC micro-rotation per cycle) and the
// S_ACC and S_DONE states that accumulate and load the output register; the
// last one stretches while an earlier result still waits there. A priming
// sample leaves the block idle. The output register lets the next sample be
// accepted while a result waits.
module wheel_odometry_integrator #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         time_ms,
  input  logic signed [31:0]  front_left_count,
  input  logic signed [31:0]  front_right_count,
  input  logic signed [31:0]  back_left_count,
  input  logic signed [31:0]  back_right_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         time_out_ms,
  output logic signed [47:0]  pos_x,
  output logic signed [47:0]  pos_y,
  output logic [31:0]         heading_before
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_SUM    = 11'b000_0000_0010,
    S_ADD    = 11'b000_0000_0100,
    S_ABS    = 11'b000_0000_1000,
    S_MUL_D  = 11'b000_0001_0000,
    S_MUL_DD = 11'b000_0010_0000,
    S_MUL_P  = 11'b000_0100_0000,
    S_MUL_X  = 11'b000_1000_0000,
    S_ROT    = 11'b001_0000_0000,
    S_ACC    = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  localparam logic signed [wodo_pkg::POS_W-1:0] POS_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [wodo_pkg::POS_W-1:0] POS_MIN = {1'b1, {47{1'b0}}};

  // Clamp a 50-bit sum to the 48-bit position range.
  function automatic logic signed [wodo_pkg::POS_W-1:0] sat48(
    input logic signed [wodo_pkg::POS_W+1:0] v
  );
    logic fits;
    fits = (v[49:47] == 3'b000) || (v[49:47] == 3'b111);
    if (fits) begin
      return v[47:0];
    end
    return v[49] ? POS_MIN : POS_MAX;
  endfunction

  state_t state;
  logic   primed;
  logic   mul_go;
  logic   rot_go;
  logic   in_fire;
  logic   out_load;

  logic [31:0] mpt;
  logic [31:0] apm;
  logic [31:0] last_fl;
  logic [31:0] last_fr;
  logic [31:0] last_bl;
  logic [31:0] last_br;
  logic signed [wodo_pkg::POS_W-1:0] x_acc;
  logic signed [wodo_pkg::POS_W-1:0] y_acc;
  logic [wodo_pkg::ANG_W-1:0]        heading_acc;

  // per-sample working registers
  logic [31:0]        time_r;
  logic signed [31:0] dfl;
  logic signed [31:0] dfr;
  logic signed [31:0] dbl;
  logic signed [31:0] dbr;
  logic signed [32:0] sl;
  logic signed [32:0] sr;
  logic signed [33:0] sum_s;
  logic signed [33:0] diff_s;
  logic [33:0]        sum_mag;
  logic [33:0]        diff_mag;
  logic               sum_neg;
  logic               diff_neg;
  logic [46:0]        d_mag;
  logic               d_neg;
  logic signed [56:0] dd;
  logic [31:0]        dtheta;
  logic [31:0]        half;
  logic [31:0]        mid;
  logic signed [wodo_pkg::XW-1:0] x0;

  logic signed [wodo_pkg::POS_W+1:0] x_sum;
  logic signed [wodo_pkg::POS_W+1:0] y_sum;

  wodo_pkg::mul_req_t mul_req;
  wodo_pkg::mul_rsp_t mul_rsp;
  wodo_pkg::rot_req_t rot_req;
  wodo_pkg::rot_rsp_t rot_rsp;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // Operand select for the shared multiplier.
  always_comb begin
    mul_req.start = mul_go;
    case (state)
      S_MUL_D: begin
        mul_req.a = {30'd0, sum_mag};
        mul_req.b = mpt;
      end
      S_MUL_DD: begin
        mul_req.a = {30'd0, diff_mag};
        mul_req.b = mpt;
      end
      S_MUL_P: begin
        mul_req.a = {{7{dd[56]}}, dd};
        mul_req.b = apm;
      end
      S_MUL_X: begin
        mul_req.a = {17'd0, d_mag};
        mul_req.b = wodo_pkg::INV_GAIN;
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  // Fold into a quarter turn: bit 31 of the folded angle equals bit 30.
  assign rot_req.start = rot_go;
  assign rot_req.x     = x0;
  assign rot_req.z     = $signed({{3{mid[30]}}, mid[30:0]});

  wodo_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  wodo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk (clk),
    .rst (rst),
    .req (rot_req),
    .rsp (rot_rsp)
  );

  assign x_sum = $signed({{2{x_acc[47]}}, x_acc}) + $signed(rot_rsp.x[57:8]);
  assign y_sum = $signed({{2{y_acc[47]}}, y_acc}) + $signed(rot_rsp.y[57:8]);

  // Sequencer and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      primed      <= 1'b0;
      mul_go      <= 1'b0;
      rot_go      <= 1'b0;
      out_valid   <= 1'b0;
      mpt         <= wodo_pkg::MPT_RESET;
      apm         <= wodo_pkg::APM_RESET;
      last_fl     <= '0;
      last_fr     <= '0;
      last_bl     <= '0;
      last_br     <= '0;
      x_acc       <= '0;
      y_acc       <= '0;
      heading_acc <= '0;
    end else begin
      // start the multiplier on entry to each multiply state, the rotator after the last
      mul_go <= (state == S_ABS) ||
                (((state == S_MUL_D) || (state == S_MUL_DD) || (state == S_MUL_P)) &&
                 mul_rsp.done);
      rot_go <= (state == S_MUL_X) && mul_rsp.done;

      if (cfg_we) begin
        case (cfg_index)
          wodo_pkg::CFG_MPT: mpt <= cfg_data;
          wodo_pkg::CFG_APM: apm <= cfg_data;
          default: ;
        endcase
      end

      // load a new result, or drop the output once the downstream side takes it
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            last_fl <= front_left_count;
            last_fr <= front_right_count;
            last_bl <= back_left_count;
            last_br <= back_right_count;
            primed  <= 1'b1;
            // a priming sample only stores the counts
            if (primed) begin
              state <= S_SUM;
            end
          end
        end
        S_SUM: state <= S_ADD;
        S_ADD: state <= S_ABS;
        S_ABS: state <= S_MUL_D;
        S_MUL_D: begin
          if (mul_rsp.done) begin
            state <= S_MUL_DD;
          end
        end
        S_MUL_DD: begin
          if (mul_rsp.done) begin
            state <= S_MUL_P;
          end
        end
        S_MUL_P: begin
          if (mul_rsp.done) begin
            state <= S_MUL_X;
          end
        end
        S_MUL_X: begin
          if (mul_rsp.done) begin
            state <= S_ROT;
          end
        end
        S_ROT: begin
          if (rot_rsp.done) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          x_acc <= sat48(x_sum);
          y_acc <= sat48(y_sum);
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_load) begin
            heading_acc <= heading_acc + dtheta;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      time_r <= time_ms;
      dfl    <= $signed(front_left_count - last_fl);
      dfr    <= $signed(front_right_count - last_fr);
      dbl    <= $signed(back_left_count - last_bl);
      dbr    <= $signed(back_right_count - last_br);
    end
    if (state == S_SUM) begin
      sl <= $signed({dfl[31], dfl}) + $signed({dbl[31], dbl});
      sr <= $signed({dfr[31], dfr}) + $signed({dbr[31], dbr});
    end
    if (state == S_ADD) begin
      sum_s  <= $signed({sl[32], sl}) + $signed({sr[32], sr});
      diff_s <= $signed({sr[32], sr}) - $signed({sl[32], sl});
    end
    if (state == S_ABS) begin
      sum_neg  <= sum_s[33];
      diff_neg <= diff_s[33];
      sum_mag  <= sum_s[33] ? $unsigned(-sum_s) : $unsigned(sum_s);
      diff_mag <= diff_s[33] ? $unsigned(-diff_s) : $unsigned(diff_s);
    end
    // travel, truncated toward zero
    if ((state == S_MUL_D) && mul_rsp.done) begin
      d_mag <= mul_rsp.prod[64:18];
      d_neg <= sum_neg;
    end
    // side difference in Q.24
    if ((state == S_MUL_DD) && mul_rsp.done) begin
      dd <= diff_neg ? -$signed({1'b0, mul_rsp.prod[64:9]})
                     : $signed({1'b0, mul_rsp.prod[64:9]});
    end
    if ((state == S_MUL_P) && mul_rsp.done) begin
      dtheta <= mul_rsp.prod[55:24];
      half   <= mul_rsp.prod[56:25];
    end
    if ((state == S_MUL_X) && mul_go) begin
      mid <= heading_acc + half;
    end
    // gain-compensated start vector, negated when the travel is negative or the angle is folded, not both
    if ((state == S_MUL_X) && mul_rsp.done) begin
      x0 <= (d_neg ^ mid[31] ^ mid[30]) ? -$signed({3'b000, mul_rsp.prod[78:24]})
                                        : $signed({3'b000, mul_rsp.prod[78:24]});
    end
    if (out_load) begin
      time_out_ms    <= time_r;
      pos_x          <= x_acc;
      pos_y          <= y_acc;
      heading_before <= heading_acc;
    end
  end

endmodule

[hdl/wodo_checker.sv]
module wodo_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [31:0]        time_out_ms,
  input logic signed [47:0] pos_x,
  input logic signed [47:0] pos_y,
  input logic [31:0]        heading_before
);

`include "wheel_odometry_integrator_assert.svh"

  logic [159:0] out_payload;

  assign out_payload = {time_out_ms, pos_x, pos_y, heading_before};

  // a pending result holds until taken
  `WODO_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "out_valid dropped early")

  `WODO_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_payload), "payload changed")

  // a result is produced only at the end of a busy stretch
  `WODO_ASSERT_IMP(a_result_after_busy, $rose(out_valid), $past(!in_ready), "result while idle")

  // leave reset idle with nothing pending
  `WODO_ASSERT_IMP(a_reset_idle, $fell(rst), in_ready && !out_valid, "not idle after reset")

endmodule

bind wheel_odometry_integrator wodo_checker u_wodo_checker (.*);
